[rtl/vrt_pkg.sv]
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants for the voxel ray traversal unit.
// ----------------------------------------------------------------------------
package vrt_pkg;
  localparam int unsigned PosFracBitsDef = 16;
  localparam int unsigned MaxStepsRst    = 50;
  localparam logic [31:0] TimeMax        = 32'hFFFF_FFFF;

  typedef struct packed {
    logic load;
    logic div_start;
    logic [2:0] div_sel;
    logic advance;
    logic out_load;
    logic [5:0] out_index;
    logic out_last;
  } vrt_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } vrt_sts_t;
endpackage

[rtl/voxel_ray_traversal_unit.sv]
// Setup: six divisions of 64 quotient bits each run before the first voxel.
// Then voxels are emitted, alternating emit and step states and waiting while
// the output is stalled; max_steps+1 voxels. Next ray after the last voxel.
// Reset: asynchronous active low; max_steps returns to 50, block idle.
// ----------------------------------------------------------------------------
// voxel_ray_traversal_unit
// 3D grid walk along a fixed-point ray, one voxel per result transaction.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_unit
  import vrt_pkg::*;
#(
  parameter int unsigned PosFracBits = PosFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_max_steps_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_y_i,
  input  logic signed [17:0] dir_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] voxel_x_o,
  output logic signed [15:0] voxel_y_o,
  output logic signed [15:0] voxel_z_o,
  output logic [5:0]         step_index_o,
  output logic               last_o
);
  vrt_cmd_t cmd;
  vrt_sts_t sts;

  vrt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cfg_we_i, .cfg_max_steps_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  vrt_datapath #(.PosFracBits(PosFracBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .origin_x_i, .origin_y_i, .origin_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .out_valid_o, .out_stall_i, .voxel_x_o, .voxel_y_o, .voxel_z_o,
    .step_index_o, .last_o
  );
endmodule

[rtl/vrt_div.sv]
// ----------------------------------------------------------------------------
// vrt_div
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, saturated
// 32-bit quotient. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrt_div
  import vrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [63:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;
  logic [33:0] diff;

  always_comb begin
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[31:0], num_q[63]};
    diff = {1'b0, trial} - {2'b00, den_i};
    if (start_i) begin
      num_d = num_i; rem_d = '0; quo_d = '0; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[62:0], 1'b0};
      if (!diff[33]) begin
        rem_d = diff[32:0]; quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial; quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = (quo_q[63:32] != '0) ? TimeMax : quo_q[31:0];
endmodule

[rtl/vrt_datapath.sv]
// ----------------------------------------------------------------------------
// vrt_datapath
// Ray setup registers, shared divider, step unit and output register.
// ----------------------------------------------------------------------------
module vrt_datapath
  import vrt_pkg::*;
#(
  parameter int unsigned PosFracBits = PosFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vrt_cmd_t           cmd_i,
  output vrt_sts_t           sts_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_y_i,
  input  logic signed [17:0] dir_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] voxel_x_o,
  output logic signed [15:0] voxel_y_o,
  output logic signed [15:0] voxel_z_o,
  output logic [5:0]         step_index_o,
  output logic               last_o
);
  localparam int unsigned DistW = PosFracBits + 1;

  logic [2:0][31:0] org_q;
  logic [2:0][17:0] mag_q;
  logic [2:0][15:0] cur_q;
  logic [2:0][31:0] tmax_q, tdel_q;
  logic [2:0]       neg_q;
  logic [2:0][17:0] dir_in;
  logic [2:0][31:0] org_in;

  logic [63:0] num;
  logic [31:0] den, quo;
  logic        div_done;
  logic [1:0]  ax;
  logic        is_dt;
  logic [DistW-1:0] gap;
  logic [PosFracBits-1:0] frac;
  logic [1:0]  adv;
  logic [32:0] tsum;

  assign dir_in = {dir_z_i, dir_y_i, dir_x_i};
  assign org_in = {origin_z_i, origin_y_i, origin_x_i};
  assign ax    = cmd_i.div_sel[2:1];
  assign is_dt = cmd_i.div_sel[0];
  assign frac  = org_q[ax][PosFracBits-1:0];
  assign gap   = neg_q[ax] ? {1'b0, frac}
                           : (DistW'(1) << PosFracBits) - {1'b0, frac};
  // gap * 2^32 / (mag * 2^frac) == gap * 2^(32 - frac) / mag
  assign num   = is_dt ? (64'd1 << 32) : (64'(gap) << (32 - PosFracBits));
  assign den   = 32'(mag_q[ax]);

  vrt_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(num), .den_i(den),
    .done_o(div_done), .quo_o(quo)
  );

  always_comb begin
    if (tmax_q[0] < tmax_q[1]) adv = (tmax_q[0] < tmax_q[2]) ? 2'd0 : 2'd2;
    else                       adv = (tmax_q[1] < tmax_q[2]) ? 2'd1 : 2'd2;
  end
  assign tsum = {1'b0, tmax_q[adv]} + {1'b0, tdel_q[adv]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= org_in[i];
        neg_q[i] <= dir_in[i][17];
        mag_q[i] <= dir_in[i][17] ? 18'(-dir_in[i]) : dir_in[i];
        cur_q[i] <= 16'($signed(org_in[i]) >>> PosFracBits);
        tmax_q[i] <= TimeMax;
        tdel_q[i] <= TimeMax;
      end
    end else if (div_done && mag_q[ax] != '0) begin
      if (is_dt) tdel_q[ax] <= quo;
      else       tmax_q[ax] <= quo;
    end else if (cmd_i.advance) begin
      cur_q[adv]  <= neg_q[adv] ? cur_q[adv] - 16'd1 : cur_q[adv] + 16'd1;
      tmax_q[adv] <= tsum[32] ? TimeMax : tsum[31:0];
    end
  end

  logic ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.out_load) ov_q <= 1'b1;
    else if (!out_stall_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      voxel_x_o <= cur_q[0]; voxel_y_o <= cur_q[1]; voxel_z_o <= cur_q[2];
      step_index_o <= cmd_i.out_index; last_o <= cmd_i.out_last;
    end
  end

  assign out_valid_o = ov_q;
  assign sts_o.div_done = div_done;
  assign sts_o.out_busy = ov_q && out_stall_i;
endmodule

[rtl/vrt_ctrl.sv]
// ----------------------------------------------------------------------------
// vrt_ctrl
// Sequencer: accept ray, run six divisions, then step and emit voxels.
// ----------------------------------------------------------------------------
module vrt_ctrl
  import vrt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     cfg_we_i,
  input  logic [5:0] cfg_max_steps_i,
  output vrt_cmd_t cmd_o,
  input  vrt_sts_t sts_i
);
  typedef enum logic [2:0] {S_IDLE, S_DSTART, S_DWAIT, S_EMIT, S_STEP} state_e;

  state_e     state_q;
  logic [2:0] sel_q;
  logic [5:0] k_q, max_q, tot_q;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = accept;
    cmd_o.div_start = (state_q == S_DSTART);
    cmd_o.div_sel = sel_q;
    cmd_o.advance = (state_q == S_STEP);
    cmd_o.out_load = (state_q == S_EMIT) && !sts_i.out_busy;
    cmd_o.out_index = k_q;
    cmd_o.out_last = (k_q == tot_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; sel_q <= '0; k_q <= '0; tot_q <= '0;
      max_q <= 6'(MaxStepsRst);
    end else begin
      if (cfg_we_i) max_q <= cfg_max_steps_i;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_DSTART; sel_q <= '0; k_q <= '0; tot_q <= max_q;
          end
        end
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (sts_i.div_done) begin
            if (sel_q == 3'd5) state_q <= S_EMIT;
            else begin
              sel_q <= sel_q + 3'd1; state_q <= S_DSTART;
            end
          end
        end
        S_EMIT: begin
          if (!sts_i.out_busy) begin
            if (k_q == tot_q) state_q <= S_IDLE;
            else state_q <= S_STEP;
          end
        end
        S_STEP: begin
          k_q <= k_q + 6'd1; state_q <= S_EMIT;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_DSTART) else $error("load not followed by setup");
  a_out_noover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy) else $error("output overwritten");
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> k_q <= tot_q) else $error("step index overrun");
endmodule
